// ===== hw/rtl/gdr_pkg.sv =====
// ============================================================================
// Gated delta-rule step: shared package
// Widths, codes, controller and datapath interface types, lookup tables and
// the fixed-point helper functions used by the gated delta-rule step block.
// ============================================================================
`default_nettype none

package gdr_pkg;

    localparam int HEAD_DIM    = 128;
    localparam int IDX_W       = $clog2(HEAD_DIM);
    localparam int CNT_W       = IDX_W + 1;
    localparam int MAT_DEPTH   = HEAD_DIM * HEAD_DIM;
    localparam int MAT_W       = 2 * IDX_W;
    localparam int DIV_STEPS   = 34;
    localparam int DIV_CNT_W   = 6;
    localparam int IN_DATA_W   = 168;
    localparam int OUT_DATA_W  = 40;
    localparam int CFG_IDX_W   = 2;

    localparam logic signed [17:0] LOG2E_Q16  = 18'sd94548;
    localparam logic        [15:0] LN1P_MAX   = 16'd45426;
    localparam logic signed [63:0] SAT_MAX    = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN    = -64'sd2147483648;

    typedef enum logic [1:0] {
        FUNC_GATE_ADD = 2'd0,
        FUNC_LOAD     = 2'd1,
        FUNC_RUN      = 2'd2,
        FUNC_READ     = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAD_DIM   = 2'd0,
        REG_DECAY_RATE = 2'd1,
        REG_STEP_BIAS  = 2'd2
    } t_reg_index;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_READ_WAIT, ST_READ_OUT, ST_GATE_X,
        ST_EXP_MUL, ST_EXP_MANT, ST_EXP_SHIFT, ST_SOFTPLUS, ST_RATE_MUL,
        ST_RATE_RND, ST_SIG_LOAD, ST_DIV_INIT, ST_DIV_STEP, ST_SAVE_BETA,
        ST_PASS_A, ST_WAIT_A, ST_DELTA_SUB, ST_DELTA_MUL, ST_DELTA_RND,
        ST_PASS_B, ST_WAIT_B, ST_COL_END, ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        PH_SOFTPLUS,
        PH_DECAY,
        PH_SIGMOID
    } t_phase;

    typedef enum logic [4:0] {
        DP_NONE, DP_GATE_ADD, DP_LOAD, DP_READ_ADDR, DP_OUT_LOAD, DP_GATE_X,
        DP_EXP_MUL, DP_EXP_MANT, DP_EXP_SHIFT, DP_SOFTPLUS, DP_RATE_MUL,
        DP_RATE_RND, DP_SIG_LOAD, DP_DIV_INIT, DP_DIV_STEP, DP_SAVE_BETA,
        DP_DELTA_SUB, DP_DELTA_MUL, DP_DELTA_RND, DP_OUT_WRITE, DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op             op;
        logic               issue;
        logic               pass_b;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic               clr_we;
        logic [MAT_W-1:0]   clr_addr;
    } t_dp_cmd;

    typedef struct packed {
        logic               pipe_empty;
        logic               out_free;
        logic [CNT_W-1:0]   dim;
    } t_dp_status;

    // 2^(i/16) in Q16.16.
    function automatic logic [17:0] exp2_tab(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // ln(1 + i/16) in Q16.16.
    function automatic logic [15:0] ln1p_tab(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41197;
            5'd15:   v = 16'd43345;
            default: v = 16'd45426;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Product rounded to Q16.16, half up, flooring shift.
    function automatic logic signed [63:0] round_q16(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd32768;
        return s >>> 16;
    endfunction

    function automatic logic [IDX_W-1:0] elem_addr(input logic [6:0] i);
        logic [15:0] w;
        w = {9'd0, i};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic elem_in_range(input logic [6:0] i);
        return {25'd0, i} < 32'(HEAD_DIM);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gated_delta_rule_step.sv =====
// ============================================================================
// Gated delta-rule step: top level
// One head's gated delta-rule recurrence for one token, Q16.16 fixed point.
// ============================================================================
// Requests arrive on the slave stream; tuser carries the function code and
// tdata the element index and the q, k, v, alpha and beta operands. Gate
// partials are added and elements loaded as the request is accepted. A run
// request evaluates the gates, using the bit-serial sigmoid divider, and then
// walks every column of the state matrix twice through a five-stage pipeline
// with a multiplier in its second and fourth stages, one row per cycle. The
// single-port-per-side matrix memory sets this rate. A read request returns
// its one response on the master stream once the index is registered, the
// output memory read and the result loaded into the output register. Only
// read requests produce a response. The block takes one request at a time; a
// response waiting on a stalled receiver sits in the output register and
// holds the next read response back until it is taken, while other requests
// proceed. After reset the state matrix is zeroed by a clearing pass over its
// HEAD_DIM*HEAD_DIM entries (16384), during which no request is accepted;
// configuration writes are always taken.
// ============================================================================
`default_nettype none

module gated_delta_rule_step
    import gdr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    // [6:0] elem_index, [38:7] q_value, [70:39] k_value, [102:71] v_value,
    // [134:103] alpha_part, [166:135] beta_part, [167] zero
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]             s_axis_tuser,
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [6:0] out_index, [38:7] out_value, [39] zero
    output      logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                   i_cfg_valid,
    output      logic                   o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);

    t_dp_cmd            cmd;
    t_dp_status         status;
    logic               cfg_write;
    logic [6:0]         out_index;
    logic signed [31:0] out_value;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    gdr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_func  (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    gdr_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_elem_index (s_axis_tdata[6:0]),
        .i_q_value    (s_axis_tdata[38:7]),
        .i_k_value    (s_axis_tdata[70:39]),
        .i_v_value    (s_axis_tdata[102:71]),
        .i_alpha_part (s_axis_tdata[134:103]),
        .i_beta_part  (s_axis_tdata[166:135]),
        .i_cfg_valid  (cfg_write),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_m_ready    (m_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .o_out_index  (out_index),
        .o_out_value  (out_value)
    );

    assign m_axis_tdata = {1'b0, out_value, out_index};

endmodule

`default_nettype wire

// ===== hw/rtl/gdr_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module gdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gdr_ctrl.sv =====
// ============================================================================
// Gated delta-rule step: controller
// Sequences the clearing pass, item handling, gate evaluation and the two
// passes over each state matrix column.
// ============================================================================
`default_nettype none

module gdr_ctrl
    import gdr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_valid,
    input  wire logic [1:0]  i_s_func,
    output      logic        o_s_ready,
    input  wire t_dp_status  i_status,
    output      t_dp_cmd     o_cmd
);

    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [IDX_W-1:0]      r_row, n_row;
    logic [IDX_W-1:0]      r_col, n_col;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [MAT_W-1:0]      r_clr, n_clr;
    logic                  row_last;
    logic                  col_last;
    logic [CNT_W-1:0]      dim_last;

    assign dim_last = CNT_W'(i_status.dim - CNT_W'(1));
    assign row_last = ({1'b0, r_row} == dim_last);
    assign col_last = ({1'b0, r_col} == dim_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_phase   <= PH_SOFTPLUS;
            r_row     <= '0;
            r_col     <= '0;
            r_div_cnt <= '0;
            r_clr     <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_row     <= n_row;
            r_col     <= n_col;
            r_div_cnt <= n_div_cnt;
            r_clr     <= n_clr;
        end
    end

    // Next state and counters.
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_row     = r_row;
        n_col     = r_col;
        n_div_cnt = r_div_cnt;
        n_clr     = r_clr;
        case (r_state)
            ST_CLEAR: begin
                n_clr = MAT_W'(r_clr + MAT_W'(1));
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_valid) begin
                    case (t_func'(i_s_func))
                        FUNC_RUN:  n_state = ST_GATE_X;
                        FUNC_READ: n_state = ST_READ_WAIT;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ_WAIT: n_state = ST_READ_OUT;
            ST_READ_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_GATE_X: begin
                n_phase = PH_SOFTPLUS;
                n_state = ST_EXP_MUL;
            end
            ST_EXP_MUL:  n_state = ST_EXP_MANT;
            ST_EXP_MANT: n_state = ST_EXP_SHIFT;
            ST_EXP_SHIFT: begin
                case (r_phase)
                    PH_SOFTPLUS: n_state = ST_SOFTPLUS;
                    PH_DECAY:    n_state = ST_SIG_LOAD;
                    default:     n_state = ST_DIV_INIT;
                endcase
            end
            ST_SOFTPLUS: n_state = ST_RATE_MUL;
            ST_RATE_MUL: n_state = ST_RATE_RND;
            ST_RATE_RND: begin
                n_phase = PH_DECAY;
                n_state = ST_EXP_MUL;
            end
            ST_SIG_LOAD: begin
                n_phase = PH_SIGMOID;
                n_state = ST_EXP_MUL;
            end
            ST_DIV_INIT: begin
                n_div_cnt = '0;
                n_state   = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                n_div_cnt = DIV_CNT_W'(r_div_cnt + DIV_CNT_W'(1));
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SAVE_BETA;
                end
            end
            ST_SAVE_BETA: begin
                n_row   = '0;
                n_col   = '0;
                n_state = ST_PASS_A;
            end
            ST_PASS_A: begin
                n_row = IDX_W'(r_row + IDX_W'(1));
                if (row_last) begin
                    n_row   = '0;
                    n_state = ST_WAIT_A;
                end
            end
            ST_WAIT_A: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_DELTA_SUB;
                end
            end
            ST_DELTA_SUB: n_state = ST_DELTA_MUL;
            ST_DELTA_MUL: n_state = ST_DELTA_RND;
            ST_DELTA_RND: n_state = ST_PASS_B;
            ST_PASS_B: begin
                n_row = IDX_W'(r_row + IDX_W'(1));
                if (row_last) begin
                    n_row   = '0;
                    n_state = ST_WAIT_B;
                end
            end
            ST_WAIT_B: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_COL_END;
                end
            end
            ST_COL_END: begin
                if (col_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_col   = IDX_W'(r_col + IDX_W'(1));
                    n_state = ST_PASS_A;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_s_ready       = 1'b0;
        o_cmd.op        = DP_NONE;
        o_cmd.issue     = 1'b0;
        o_cmd.pass_b    = 1'b0;
        o_cmd.row       = r_row;
        o_cmd.col       = r_col;
        o_cmd.clr_we    = 1'b0;
        o_cmd.clr_addr  = r_clr;
        case (r_state)
            ST_CLEAR: o_cmd.clr_we = 1'b1;
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    case (t_func'(i_s_func))
                        FUNC_GATE_ADD: o_cmd.op = DP_GATE_ADD;
                        FUNC_LOAD:     o_cmd.op = DP_LOAD;
                        FUNC_READ:     o_cmd.op = DP_READ_ADDR;
                        default:       o_cmd.op = DP_NONE;
                    endcase
                end
            end
            ST_READ_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = DP_OUT_LOAD;
                end
            end
            ST_GATE_X:    o_cmd.op = DP_GATE_X;
            ST_EXP_MUL:   o_cmd.op = DP_EXP_MUL;
            ST_EXP_MANT:  o_cmd.op = DP_EXP_MANT;
            ST_EXP_SHIFT: o_cmd.op = DP_EXP_SHIFT;
            ST_SOFTPLUS:  o_cmd.op = DP_SOFTPLUS;
            ST_RATE_MUL:  o_cmd.op = DP_RATE_MUL;
            ST_RATE_RND:  o_cmd.op = DP_RATE_RND;
            ST_SIG_LOAD:  o_cmd.op = DP_SIG_LOAD;
            ST_DIV_INIT:  o_cmd.op = DP_DIV_INIT;
            ST_DIV_STEP:  o_cmd.op = DP_DIV_STEP;
            ST_SAVE_BETA: o_cmd.op = DP_SAVE_BETA;
            ST_PASS_A:    o_cmd.issue = 1'b1;
            ST_DELTA_SUB: o_cmd.op = DP_DELTA_SUB;
            ST_DELTA_MUL: o_cmd.op = DP_DELTA_MUL;
            ST_DELTA_RND: o_cmd.op = DP_DELTA_RND;
            ST_PASS_B: begin
                o_cmd.issue  = 1'b1;
                o_cmd.pass_b = 1'b1;
            end
            ST_COL_END:   o_cmd.op = DP_OUT_WRITE;
            ST_FINISH:    o_cmd.op = DP_FINISH;
            default:      o_cmd.op = DP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gdr_dpath.sv =====
// ============================================================================
// Gated delta-rule step: datapath
// Configuration registers, gate sums, the shared exp unit, the sigmoid
// divider, the element stores, the state matrix and its column pipeline.
// ============================================================================
`default_nettype none

module gdr_dpath
    import gdr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output      t_dp_status            o_status,
    input  wire logic [6:0]            i_elem_index,
    input  wire logic signed [31:0]    i_q_value,
    input  wire logic signed [31:0]    i_k_value,
    input  wire logic signed [31:0]    i_v_value,
    input  wire logic signed [31:0]    i_alpha_part,
    input  wire logic signed [31:0]    i_beta_part,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]           i_cfg_data,
    input  wire logic                  i_m_ready,
    output      logic                  o_m_valid,
    output      logic [6:0]            o_out_index,
    output      logic signed [31:0]    o_out_value
);

    // Configuration and gate sums.
    logic        [7:0]  r_head_dim;
    logic signed [31:0] r_rate;
    logic signed [31:0] r_bias;
    logic signed [31:0] r_alpha_sum;
    logic signed [31:0] r_beta_sum;

    // Gate evaluation.
    logic signed [31:0] r_pos;
    logic signed [32:0] r_exp_y;
    logic signed [50:0] r_exp_p;
    logic        [17:0] r_exp_m;
    logic signed [18:0] r_exp_n;
    logic signed [31:0] r_exp_res;
    logic signed [31:0] r_sp;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_decay;
    logic signed [31:0] r_beta;
    logic        [32:0] r_div_den;
    logic        [33:0] r_div_num;
    logic        [33:0] r_div_rem;
    logic signed [31:0] r_diff;
    logic signed [31:0] r_delta;
    logic signed [63:0] r_acc;

    // Column pipeline.
    logic               r_v1, r_v2, r_v3, r_v4;
    logic               r_b1, r_b2;
    logic [MAT_W-1:0]   r_addr1, r_addr2, r_addr3;
    logic signed [63:0] r_p1, r_p2;
    logic signed [31:0] r_s2, r_o2, r_s3, r_o3;

    // Read-out.
    logic [6:0]         r_rd_index;
    logic               r_rd_oob;

    // Memory ports.
    logic [31:0]        q_rdata, k_rdata, v_rdata, o_rdata, s_rdata;
    logic               load_we;
    logic [IDX_W-1:0]   load_addr;
    logic               mat_we;
    logic [MAT_W-1:0]   mat_waddr;
    logic [31:0]        mat_wdata;
    logic               out_we;

    // Combinational helpers.
    logic [15:0]        dim_ext;
    logic [3:0]         mant_i;
    logic [11:0]        mant_r;
    logic [17:0]        mant_t0, mant_t1;
    logic [29:0]        mant_frac;
    logic [32:0]        sh_left;
    logic signed [18:0] n_neg;
    logic signed [31:0] exp_shifted;
    logic [15:0]        ln_val;
    logic [15:0]        ln_t0, ln_t1;
    logic [27:0]        ln_frac;
    logic signed [31:0] gate_x;
    logic [34:0]        div_sh;
    logic               div_bit;
    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] stage3_x;

    assign load_we   = (i_cmd.op == DP_LOAD) && elem_in_range(i_elem_index);
    assign load_addr = elem_addr(i_elem_index);
    assign out_we    = (i_cmd.op == DP_OUT_WRITE);

    gdr_ram #(.WIDTH(32), .DEPTH(HEAD_DIM)) u_q_ram (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(load_addr), .i_wdata(i_q_value),
        .i_raddr(i_cmd.row), .o_rdata(q_rdata)
    );
    gdr_ram #(.WIDTH(32), .DEPTH(HEAD_DIM)) u_k_ram (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(load_addr), .i_wdata(i_k_value),
        .i_raddr(i_cmd.row), .o_rdata(k_rdata)
    );
    gdr_ram #(.WIDTH(32), .DEPTH(HEAD_DIM)) u_v_ram (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(load_addr), .i_wdata(i_v_value),
        .i_raddr(i_cmd.col), .o_rdata(v_rdata)
    );
    gdr_ram #(.WIDTH(32), .DEPTH(HEAD_DIM)) u_out_ram (
        .i_clk(i_clk), .i_we(out_we), .i_waddr(i_cmd.col), .i_wdata(sat32(r_acc)),
        .i_raddr(elem_addr(r_rd_index)), .o_rdata(o_rdata)
    );

    assign mat_we    = i_cmd.clr_we || r_v3;
    assign mat_waddr = i_cmd.clr_we ? i_cmd.clr_addr : r_addr3;
    assign mat_wdata = i_cmd.clr_we ? 32'd0 : r_s3;

    gdr_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_mat_ram (
        .i_clk(i_clk), .i_we(mat_we), .i_waddr(mat_waddr), .i_wdata(mat_wdata),
        .i_raddr({i_cmd.row, i_cmd.col}), .o_rdata(s_rdata)
    );

    // Effective dimension: out-of-range settings fall back to the full size.
    assign dim_ext = {8'd0, r_head_dim};
    always_comb begin
        if (r_head_dim == 8'd0 || dim_ext > 16'(HEAD_DIM)) begin
            o_status.dim = CNT_W'(HEAD_DIM);
        end else begin
            o_status.dim = dim_ext[CNT_W-1:0];
        end
    end
    assign o_status.pipe_empty = !(r_v1 || r_v2 || r_v3 || r_v4);
    assign o_status.out_free   = !o_m_valid || i_m_ready;

    // Exp mantissa from the fractional part of t.
    assign mant_i    = r_exp_p[31:28];
    assign mant_r    = r_exp_p[27:16];
    assign mant_t0   = exp2_tab({1'b0, mant_i});
    assign mant_t1   = exp2_tab(5'({1'b0, mant_i} + 5'd1));
    assign mant_frac = 30'(mant_t1 - mant_t0) * 30'(mant_r);

    // Exp scaling by 2^n.
    assign sh_left = 33'(r_exp_m) << r_exp_n[3:0];
    assign n_neg   = -r_exp_n;
    always_comb begin
        if (r_exp_n >= 19'sd15) begin
            exp_shifted = 32'sh7FFFFFFF;
        end else if (!r_exp_n[18]) begin
            exp_shifted = (sh_left > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : sh_left[31:0];
        end else if (r_exp_n <= -19'sd32) begin
            exp_shifted = 32'sd0;
        end else begin
            exp_shifted = 32'(r_exp_m >> n_neg[4:0]);
        end
    end

    // ln(1+u) on the exp result.
    assign ln_t0   = ln1p_tab({1'b0, r_exp_res[15:12]});
    assign ln_t1   = ln1p_tab(5'({1'b0, r_exp_res[15:12]} + 5'd1));
    assign ln_frac = 28'(ln_t1 - ln_t0) * 28'(r_exp_res[11:0]);
    always_comb begin
        if (r_exp_res <= 32'sd0) begin
            ln_val = 16'd0;
        end else if (r_exp_res >= 32'sd65536) begin
            ln_val = LN1P_MAX;
        end else begin
            ln_val = 16'(ln_t0 + 16'(ln_frac >> 12));
        end
    end

    assign gate_x  = sat32(64'(r_alpha_sum) + 64'(r_bias));
    assign div_sh  = {r_div_rem, r_div_num[33]};
    assign div_bit = (div_sh >= {2'd0, r_div_den});

    assign mul_a    = r_b1 ? $signed(k_rdata) : $signed(s_rdata);
    assign mul_b    = r_b1 ? r_delta : r_decay;
    assign stage3_x = sat32(round_q16(r_p1));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_dim  <= 8'd128;
            r_rate      <= -32'sd65536;
            r_bias      <= 32'sd0;
            r_alpha_sum <= 32'sd0;
            r_beta_sum  <= 32'sd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            o_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg_index'(i_cfg_index))
                    REG_HEAD_DIM:   r_head_dim <= i_cfg_data[7:0];
                    REG_DECAY_RATE: r_rate     <= $signed(i_cfg_data);
                    REG_STEP_BIAS:  r_bias     <= $signed(i_cfg_data);
                    default:        r_head_dim <= r_head_dim;
                endcase
            end
            if (i_cmd.op == DP_GATE_ADD) begin
                r_alpha_sum <= sat32(64'(r_alpha_sum) + 64'(i_alpha_part));
                r_beta_sum  <= sat32(64'(r_beta_sum) + 64'(i_beta_part));
            end else if (i_cmd.op == DP_FINISH) begin
                r_alpha_sum <= 32'sd0;
                r_beta_sum  <= 32'sd0;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.op == DP_OUT_LOAD) begin
                o_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                o_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_READ_ADDR: begin
                r_rd_index <= i_elem_index;
                r_rd_oob   <= !elem_in_range(i_elem_index);
            end
            DP_OUT_LOAD: begin
                o_out_index <= r_rd_index;
                o_out_value <= r_rd_oob ? 32'sd0 : $signed(o_rdata);
            end
            DP_GATE_X: begin
                if (gate_x > 32'sd0) begin
                    r_pos   <= gate_x;
                    r_exp_y <= -33'(gate_x);
                end else begin
                    r_pos   <= 32'sd0;
                    r_exp_y <= 33'(gate_x);
                end
            end
            DP_EXP_MUL:   r_exp_p <= 51'(r_exp_y) * 51'(LOG2E_Q16);
            DP_EXP_MANT: begin
                r_exp_m <= 18'(mant_t0 + 18'(mant_frac >> 12));
                r_exp_n <= r_exp_p[50:32];
            end
            DP_EXP_SHIFT: r_exp_res <= exp_shifted;
            DP_SOFTPLUS:  r_sp <= sat32(64'(r_pos) + 64'(ln_val));
            DP_RATE_MUL:  r_prod <= 64'(r_rate) * 64'(r_sp);
            DP_RATE_RND:  r_exp_y <= 33'(sat32(round_q16(r_prod)));
            DP_SIG_LOAD: begin
                r_decay <= r_exp_res;
                r_exp_y <= -33'(r_beta_sum);
            end
            DP_DIV_INIT: begin
                r_div_den <= 33'd65536 + {1'b0, r_exp_res};
                r_div_num <= 34'h100000000
                             + 34'((33'd65536 + {1'b0, r_exp_res}) >> 1);
                r_div_rem <= 34'd0;
            end
            DP_DIV_STEP: begin
                r_div_rem <= div_bit ? 34'(div_sh - {2'd0, r_div_den}) : div_sh[33:0];
                r_div_num <= {r_div_num[32:0], div_bit};
            end
            DP_SAVE_BETA: r_beta <= r_div_num[31:0];
            DP_DELTA_SUB: r_diff <= sat32(64'($signed(v_rdata)) - 64'(sat32(r_acc)));
            DP_DELTA_MUL: r_prod <= 64'(r_diff) * 64'(r_beta);
            DP_DELTA_RND: r_delta <= sat32(round_q16(r_prod));
            default: begin
            end
        endcase

        // Accumulator: cleared between passes, summed from the last stage.
        if (i_cmd.op == DP_SAVE_BETA || i_cmd.op == DP_DELTA_RND
                || i_cmd.op == DP_OUT_WRITE) begin
            r_acc <= 64'sd0;
        end else if (r_v4) begin
            r_acc <= r_acc + round_q16(r_p2);
        end

        // Column pipeline: read, multiply, round/update, multiply, accumulate.
        r_b1    <= i_cmd.pass_b;
        r_addr1 <= {i_cmd.row, i_cmd.col};
        r_p1    <= 64'(mul_a) * 64'(mul_b);
        r_s2    <= $signed(s_rdata);
        r_o2    <= r_b1 ? $signed(q_rdata) : $signed(k_rdata);
        r_b2    <= r_b1;
        r_addr2 <= r_addr1;
        r_s3    <= r_b2 ? sat32(64'(r_s2) + 64'(stage3_x)) : stage3_x;
        r_o3    <= r_o2;
        r_addr3 <= r_addr2;
        r_p2    <= 64'(r_s3) * 64'(r_o3);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gdr_checker.sv =====
// ============================================================================
// Gated delta-rule step: port checker
// Watches the top-level ports for reset, handshake and response ordering.
// ============================================================================
`default_nettype none

module gdr_checker
    import gdr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic [1:0]             s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);

    // Reset empties the output register and starts the clearing pass.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("outputs active after reset");

    // A stalled response holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled response changed");

    // A response is loaded only after the block has stopped taking requests.
    a_resp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("response appeared without a read in flight");

    // A request other than a read never yields a response in the next cycle.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid
            && s_axis_tuser != FUNC_READ) |=> !m_axis_tvalid)
        else $error("response without a read request");

    // Only an idle block accepts, so no request is taken while a read is running.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_READ)
            |=> !s_axis_tready)
        else $error("request accepted during a read");

endmodule

bind gated_delta_rule_step gdr_checker u_gdr_checker (.*);

`default_nettype wire
